// ===== hdl/vtv_pkg.sv =====
// Shared widths, config register indices and stage-to-stage types for the vertex transform.
package vtv_pkg;

    localparam int IN_W    = 32;  // Q16.16 vertex component
    localparam int COEF_W  = 16;  // Q8.8 matrix coefficient
    localparam int PROD_W  = IN_W + COEF_W;  // Q24.24 product
    localparam int SUM_W   = PROD_W + 2;     // sum of four products
    localparam int MAG_W   = SUM_W;          // |clip + |w||
    localparam int SIZE_W  = 13;
    localparam int NUM_W   = MAG_W + SIZE_W; // magnitude times screen size
    localparam int DEN_W   = SUM_W;          // 2 * |w|
    localparam int QB      = 17;             // quotient bits kept
    localparam int CMP_W   = DEN_W + QB;
    localparam int PIX_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ROW_W   = 4 * COEF_W;

    // pipeline: 4 transform stages, overflow check + QB division steps, output register
    localparam int XF_ST   = 4;
    localparam int DIV_ST  = QB + 1;
    localparam int NST     = XF_ST + DIV_ST + 1;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(480);

    localparam logic [PIX_W-1:0] PIX_MAX = 16'h7FFF;
    localparam logic [PIX_W-1:0] PIX_MIN = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X    = 3'd0,
        CFG_ROW_Y    = 3'd1,
        CFG_ROW_W    = 3'd2,
        CFG_SCREEN_W = 3'd3,
        CFG_SCREEN_H = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [DEN_W-1:0] den;
        logic             neg_x;
        logic             neg_y;
        logic             w_zero;
    } t_div_in;

endpackage

// ===== hdl/vertex_transform_viewport.sv =====
// Top level: config registers, stage valids and stall chain, divider pair, output register.
//
//  channel  | direction | transaction moves
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | one vertex: tdata = x, y, z, w (Q16.16, 32 bits each)
//  m_axis   | out       | one pixel: tdata = pixel_x, pixel_y; tuser = flags
//  cfg      | in        | one register write: index, 64-bit data
//
// One vertex per cycle unless m_axis stalls. Stages: four transform stages,
// an overflow check and seventeen restoring-division stages, one per quotient
// bit, then the output register. Each stage has its own valid bit and holds
// only while it is full and the stage after it holds, so bubbles are squeezed
// out and the input keeps flowing while a result waits at the output.
// Reset clears the valids and loads the config defaults (640 x 480, zero rows).
// cfg is always ready; rows and sizes must only change with the pipe empty.
module vertex_transform_viewport
    import vtv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [4*IN_W-1:0]    i_s_axis_tdata,   // vertex_x, vertex_y, vertex_z, vertex_w
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [2*PIX_W-1:0]   o_m_axis_tdata,   // pixel_x, pixel_y
    output logic [1:0]           o_m_axis_tuser,   // w_is_zero, saturated
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROW_W-1:0]     i_cfg_wdata
);

    logic [ROW_W-1:0]  r_row_x, r_row_y, r_row_w;
    logic [SIZE_W-1:0] r_width, r_height;
    logic [NST-1:0]    r_valid;
    logic [NST-1:0]    en;

    t_div_in           xf;
    logic [QB-1:0]     q_x, q_y;
    logic              ovf_x, ovf_y;
    logic [1:0]        side_x;
    logic              side_y;

    logic [PIX_W-1:0]  n_px, n_py;
    logic              n_sat;
    logic              sat_x, sat_y;
    logic [PIX_W-1:0]  r_px, r_py;
    logic              r_wz, r_sat;

    // ---- configuration -------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x  <= '0;
            r_row_y  <= '0;
            r_row_w  <= '0;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROW_X:    r_row_x  <= i_cfg_wdata;
                CFG_ROW_Y:    r_row_y  <= i_cfg_wdata;
                CFG_ROW_W:    r_row_w  <= i_cfg_wdata;
                CFG_SCREEN_W: r_width  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_SCREEN_H: r_height <= i_cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- stall chain: a stage loads when empty or when the next one loads
    always_comb begin
        en[NST-1] = !r_valid[NST-1] || i_m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // ---- datapath ------------------------------------------------------
    vtv_transform u_xf (
        .i_clk    (i_clk),
        .i_en     (en[XF_ST-1:0]),
        .i_vertex (i_s_axis_tdata),
        .i_row_x  (r_row_x),
        .i_row_y  (r_row_y),
        .i_row_w  (r_row_w),
        .i_width  (r_width),
        .i_height (r_height),
        .o_div    (xf)
    );

    vtv_div #(.SIDE_W(2)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (en[XF_ST +: DIV_ST]),
        .i_num  (xf.num_x),
        .i_den  (xf.den),
        .i_side ({xf.w_zero, xf.neg_x}),
        .o_quot (q_x),
        .o_ovf  (ovf_x),
        .o_side (side_x)
    );

    vtv_div #(.SIDE_W(1)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (en[XF_ST +: DIV_ST]),
        .i_num  (xf.num_y),
        .i_den  (xf.den),
        .i_side (xf.neg_y),
        .o_quot (q_y),
        .o_ovf  (ovf_y),
        .o_side (side_y)
    );

    // ---- sign, clamp, zero-w override ----------------------------------
    // positive side clamps above 32767, negative side below -32768
    always_comb begin
        sat_x = ovf_x || (side_x[0] ? (q_x > QB'(32768)) : (q_x > QB'(32767)));
        sat_y = ovf_y || (side_y    ? (q_y > QB'(32768)) : (q_y > QB'(32767)));
        if (sat_x) begin
            n_px = side_x[0] ? PIX_MIN : PIX_MAX;
        end else begin
            n_px = side_x[0] ? PIX_W'(-q_x) : q_x[PIX_W-1:0];
        end
        if (sat_y) begin
            n_py = side_y ? PIX_MIN : PIX_MAX;
        end else begin
            n_py = side_y ? PIX_W'(-q_y) : q_y[PIX_W-1:0];
        end
        n_sat = sat_x || sat_y;
        if (side_x[1]) begin
            n_px  = '0;
            n_py  = '0;
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_wz  <= side_x[1];
            r_sat <= n_sat;
        end
    end

    assign o_m_axis_tvalid = r_valid[NST-1];
    assign o_m_axis_tdata  = {r_py, r_px};
    assign o_m_axis_tuser  = {r_sat, r_wz};

    // ---- checks ----------------------------------------------------------
    a_wz_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0 && !o_m_axis_tuser[1])
        else $error("zero w with non-zero pixel or saturation");

    a_sat_rail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
            o_m_axis_tdata[15:0] == PIX_MAX || o_m_axis_tdata[15:0] == PIX_MIN ||
            o_m_axis_tdata[31:16] == PIX_MAX || o_m_axis_tdata[31:16] == PIX_MIN)
        else $error("saturation flag without a clamped coordinate");

    a_accept_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_valid[0])
        else $error("accepted vertex not captured in first stage");

endmodule

// ===== hdl/vtv_transform.sv =====
// Matrix rows, |w|, viewport offset and screen-size scaling over four stages.
module vtv_transform
    import vtv_pkg::*;
(
    input  logic                  i_clk,
    input  logic [XF_ST-1:0]      i_en,
    input  logic [4*IN_W-1:0]     i_vertex,
    input  logic [ROW_W-1:0]      i_row_x,
    input  logic [ROW_W-1:0]      i_row_y,
    input  logic [ROW_W-1:0]      i_row_w,
    input  logic [SIZE_W-1:0]     i_width,
    input  logic [SIZE_W-1:0]     i_height,
    output t_div_in               o_div
);

    logic signed [PROD_W-1:0] r_prod [0:2][0:3];
    logic signed [SUM_W-1:0]  r_cx, r_cy, r_cw;
    logic [MAG_W-1:0]         r_mag_x, r_mag_y;
    logic [DEN_W-1:0]         r_den3;
    logic                     r_neg_x3, r_neg_y3, r_wz3;
    t_div_in                  r_out;

    logic [ROW_W-1:0]         rows [0:2];
    logic signed [SUM_W-1:0]  aw;
    logic signed [SUM_W:0]    num_x, num_y;

    assign rows[0] = i_row_x;
    assign rows[1] = i_row_y;
    assign rows[2] = i_row_w;

    // stage 1: twelve 16x32 products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[r][j] <= PROD_W'($signed(rows[r][j*COEF_W +: COEF_W]))
                                  * PROD_W'($signed(i_vertex[j*IN_W +: IN_W]));
                end
            end
        end
    end

    // stage 2: dot products
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_cx <= SUM_W'(r_prod[0][0]) + SUM_W'(r_prod[0][1])
                  + SUM_W'(r_prod[0][2]) + SUM_W'(r_prod[0][3]);
            r_cy <= SUM_W'(r_prod[1][0]) + SUM_W'(r_prod[1][1])
                  + SUM_W'(r_prod[1][2]) + SUM_W'(r_prod[1][3]);
            r_cw <= SUM_W'(r_prod[2][0]) + SUM_W'(r_prod[2][1])
                  + SUM_W'(r_prod[2][2]) + SUM_W'(r_prod[2][3]);
        end
    end

    // stage 3: c + |w| and its sign/magnitude; |w| never exceeds 2^48
    always_comb begin
        aw    = r_cw[SUM_W-1] ? -r_cw : r_cw;
        num_x = (SUM_W+1)'(r_cx) + (SUM_W+1)'(aw);
        num_y = (SUM_W+1)'(r_cy) + (SUM_W+1)'(aw);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_neg_x3 <= num_x[SUM_W];
            r_neg_y3 <= num_y[SUM_W];
            r_mag_x  <= MAG_W'(num_x[SUM_W] ? -num_x : num_x);
            r_mag_y  <= MAG_W'(num_y[SUM_W] ? -num_y : num_y);
            r_den3   <= DEN_W'({aw, 1'b0});
            r_wz3    <= (r_cw == '0);
        end
    end

    // stage 4: scale by screen size
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_out.num_x  <= NUM_W'(r_mag_x) * NUM_W'(i_width);
            r_out.num_y  <= NUM_W'(r_mag_y) * NUM_W'(i_height);
            r_out.den    <= r_den3;
            r_out.neg_x  <= r_neg_x3;
            r_out.neg_y  <= r_neg_y3;
            r_out.w_zero <= r_wz3;
        end
    end

    assign o_div = r_out;

endmodule

// ===== hdl/vtv_div.sv =====
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
module vtv_div
    import vtv_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic [DIV_ST-1:0] i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [QB-1:0]     o_quot,
    output logic              o_ovf,
    output logic [SIDE_W-1:0] o_side
);

    logic [NUM_W-1:0]  r_rem  [0:QB];
    logic [DEN_W-1:0]  r_den  [0:QB];
    logic [QB-1:0]     r_q    [0:QB];
    logic              r_ovf  [0:QB];
    logic [SIDE_W-1:0] r_side [0:QB];

    // quotient of 2^QB or more is flagged here and never resolved
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= {{(CMP_W-NUM_W){1'b0}}, i_num} >= {i_den, {QB{1'b0}}};
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        localparam int BIT = QB - k;
        logic [CMP_W-1:0] sub;
        logic [CMP_W-1:0] rem_ext;
        logic             ge;

        always_comb begin
            sub     = {{QB{1'b0}}, r_den[k-1]} << BIT;
            rem_ext = {{(CMP_W-NUM_W){1'b0}}, r_rem[k-1]};
            ge      = rem_ext >= sub;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= ge ? NUM_W'(rem_ext - sub) : r_rem[k-1];
                r_q[k]    <= r_q[k-1] | (ge ? (QB'(1) << BIT) : '0);
                r_den[k]  <= r_den[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_quot = r_q[QB];
    assign o_ovf  = r_ovf[QB];
    assign o_side = r_side[QB];

endmodule

// ===== verif/testbench.sv =====
// Testbench for vertex_transform_viewport: scoreboard with exact rational predictor.
`timescale 1ns / 100ps

module testbench
    import vtv_pkg::*;
();

    // Scoreboard: holds the configuration copy and the queue of expected pixels.
    class pixel_scoreboard;
        logic [ROW_W-1:0]  row_x, row_y, row_w;
        logic [SIZE_W-1:0] scr_w, scr_h;
        logic [PIX_W-1:0]  exp_px[$];
        logic [PIX_W-1:0]  exp_py[$];
        logic              exp_wz[$];
        logic              exp_sat[$];
        int                errors;

        function new();
            row_x = '0; row_y = '0; row_w = '0;
            scr_w = RST_WIDTH; scr_h = RST_HEIGHT;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [ROW_W-1:0] val);
            case (idx)
                CFG_ROW_X:    row_x = val;
                CFG_ROW_Y:    row_y = val;
                CFG_ROW_W:    row_w = val;
                CFG_SCREEN_W: scr_w = val[SIZE_W-1:0];
                CFG_SCREEN_H: scr_h = val[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint dot(logic [ROW_W-1:0] row, logic [4*IN_W-1:0] vtx);
            longint acc;
            acc = 0;
            for (int j = 0; j < 4; j++)
                acc += longint'($signed(row[16*j +: 16])) * longint'($signed(vtx[32*j +: 32]));
            return acc;
        endfunction

        // (c + |w|) * S / (2|w|), truncated toward zero, clamped to 16 bits
        function logic [PIX_W-1:0] map_axis(longint c, longint aw, logic [SIZE_W-1:0] sz,
                                            inout logic sat);
            longint num;
            logic [127:0] mag, q;
            logic neg;
            num = c + aw;
            neg = num < 0;
            mag = neg ? 128'(-num) : 128'(num);
            q = (mag * 128'(sz)) / (128'(aw) * 2);
            if (neg) begin
                if (q > 32768) begin
                    sat = 1'b1;
                    return PIX_MIN;
                end
                return PIX_W'(-q);
            end
            if (q > 32767) begin
                sat = 1'b1;
                return PIX_MAX;
            end
            return PIX_W'(q);
        endfunction

        function void note_vertex(logic [4*IN_W-1:0] vtx);
            longint cx, cy, cw, aw;
            logic sat;
            logic [PIX_W-1:0] px, py;
            cx = dot(row_x, vtx);
            cy = dot(row_y, vtx);
            cw = dot(row_w, vtx);
            sat = 1'b0;
            if (cw == 0) begin
                exp_px.push_back('0); exp_py.push_back('0);
                exp_wz.push_back(1'b1); exp_sat.push_back(1'b0);
            end else begin
                aw = cw < 0 ? -cw : cw;
                px = map_axis(cx, aw, scr_w, sat);
                py = map_axis(cy, aw, scr_h, sat);
                exp_px.push_back(px); exp_py.push_back(py);
                exp_wz.push_back(1'b0); exp_sat.push_back(sat);
            end
        endfunction

        task report(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
            errors++;
        endtask

        task check_pixel(logic [2*PIX_W-1:0] data, logic [1:0] flags);
            logic [PIX_W-1:0] px, py;
            logic wz, sat;
            if (exp_px.size() == 0) begin
                $display("%0t: pixel %h with none expected", $time, data);
                errors++;
                return;
            end
            px = exp_px.pop_front(); py = exp_py.pop_front();
            wz = exp_wz.pop_front(); sat = exp_sat.pop_front();
            if (data[PIX_W-1:0] !== px) report("pixel_x", data[PIX_W-1:0], px);
            if (data[2*PIX_W-1:PIX_W] !== py) report("pixel_y", data[2*PIX_W-1:PIX_W], py);
            if (flags[0] !== wz) report("w_is_zero", 16'(flags[0]), 16'(wz));
            if (flags[1] !== sat) report("saturated", 16'(flags[1]), 16'(sat));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid, s_tready;
    logic [4*IN_W-1:0]    s_tdata;
    logic                 m_tvalid, m_tready;
    logic [2*PIX_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_wdata;

    pixel_scoreboard sb;
    int send_idle_pct;   // chance the sender gaps before a transaction
    int recv_idle_pct;   // chance the receiver stalls on a given cycle

    vertex_transform_viewport DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop; comfortably above the slowest legal run.
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random back-pressure, checking on the rising edge.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tuser);
    end

    task send_vertex(logic [4*IN_W-1:0] vtx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vtx;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_vertex(vtx);
        @(negedge i_clk);
    endtask

    // Only called with the pipe drained; the caller drops cfg_valid after the last write.
    task write_reg(t_cfg_idx idx, logic [ROW_W-1:0] val);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (sb.exp_px.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Q8.8 coefficient near typical values, occasionally fully random
    function logic [15:0] rand_coef();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(1024)) - 512);
    endfunction

    function logic [63:0] rand_row();
        return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    endfunction

    // Q16.16 vertex: mostly moderate coordinates with w between 0 and 2.0, some noise
    function logic [4*IN_W-1:0] rand_vertex();
        logic [31:0] c[4];
        if ($urandom_range(4) == 0)
            return {$urandom, $urandom, $urandom, $urandom};
        for (int j = 0; j < 3; j++)
            c[j] = 32'($signed($urandom_range(32'h40000)) - 32'sh20000);
        c[3] = 32'($signed($urandom_range(32'h20000)));
        return {c[3], c[2], c[1], c[0]};
    endfunction

    task set_view(logic [63:0] rx, logic [63:0] ry, logic [63:0] rw,
                  logic [12:0] w, logic [12:0] h);
        write_reg(CFG_ROW_X, rx);
        write_reg(CFG_ROW_Y, ry);
        write_reg(CFG_ROW_W, rw);
        write_reg(CFG_SCREEN_W, 64'(w));
        write_reg(CFG_SCREEN_H, 64'(h));
        cfg_valid <= 1'b0;
    endtask

    localparam logic [63:0] ID_X = 64'h0000_0000_0000_0100;
    localparam logic [63:0] ID_Y = 64'h0000_0000_0100_0000;
    localparam logic [63:0] ID_W = 64'h0100_0000_0000_0000;

    initial begin
        logic [63:0] big_row;
        sb = new();
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROW_X;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset rows are zero: every vertex hits the zero-w case.
        send_vertex({32'h0001_0000, 32'h0, 32'h0, 32'h0});
        send_vertex({4{32'hFFFF_FFFF}});
        drain();

        // Identity, 640x480: centre, edges, negative w, overflow, zero w.
        set_view(ID_X, ID_Y, ID_W, 13'd640, 13'd480);
        send_vertex({32'h0001_0000, 32'h0, 32'h0, 32'h0});
        send_vertex({32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'hFFFF_0000});
        send_vertex({32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000});
        send_vertex({32'hFFFF_0000, 32'h0, 32'h0000_8000, 32'hFFFF_8000});
        send_vertex({32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000});
        send_vertex({32'h0000_0001, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF});
        send_vertex({32'h0, 32'h0, 32'h1234_5678, 32'h8765_4321});
        send_vertex({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        send_vertex({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        drain();

        // Extreme coefficients and sizes: largest products, size 0 and 8191.
        big_row = 64'h8000_7FFF_8000_7FFF;
        set_view(big_row, ~big_row, 64'h8000_8000_8000_8000, 13'd8191, 13'd0);
        send_vertex({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_vertex({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_vertex({32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF});
        send_vertex({32'h0000_0001, 32'h0, 32'h0, 32'h0});
        drain();
        set_view(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, ID_W, 13'd1, 13'd4096);
        send_vertex({32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_vertex({32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000});
        drain();

        // Random phases: each pass picks its idling profile and a new view.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin send_idle_pct = 10; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph % 3 == 0)
                set_view(ID_X | 64'(rand_coef()) << 48, ID_Y | 64'(rand_coef()) << 48,
                         ID_W | 64'(rand_coef()), 13'($urandom_range(1, 4096)),
                         13'($urandom_range(1, 4096)));
            else if (ph % 3 == 1)
                set_view(rand_row(), rand_row(), rand_row(),
                         13'($urandom), 13'($urandom));
            else
                set_view(rand64(), rand64(), rand64(), 13'd4096, 13'd1);
            for (int n = 0; n < 50; n++)
                send_vertex(rand_vertex());
            drain();
        end

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/vtv_pkg.sv
hdl/vtv_transform.sv
hdl/vtv_div.sv
hdl/vertex_transform_viewport.sv
verif/testbench.sv
